/* rtl/isaa_pkg.sv */
// ----------------------------------------------------------------------------
// isaa_pkg
// Shared types and constants for the IMU sample scaling and averaging core.
// ----------------------------------------------------------------------------
`default_nettype none

package isaa_pkg;

  localparam int RING_LOG2  = 2;
  localparam int TAPS       = 1 << RING_LOG2;
  localparam int RAW_W      = 16;
  localparam int SUM_W      = RAW_W + RING_LOG2;
  localparam int GAIN_W     = 25;
  localparam int PROD_W     = SUM_W + GAIN_W + 1;
  localparam int OUT_W      = 32;
  localparam int FRAC_SHIFT = 8;
  localparam int CFG_W      = 25;
  localparam int CFG_IDX_W  = 3;

  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = GAIN_W'(1024);
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = GAIN_W'(128070);
  localparam logic [GAIN_W-1:0] TEMP_GAIN_RST  = GAIN_W'(49345);
  localparam logic [CFG_W-1:0]  TEMP_BIAS_RST  = CFG_W'(2394030);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_GAIN    = 3'd0,
    REG_GYRO_GAIN     = 3'd1,
    REG_TEMP_GAIN     = 3'd2,
    REG_TEMP_BIAS     = 3'd3,
    REG_FILTER_ENABLE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] accel_x_raw;
    logic signed [RAW_W-1:0] accel_y_raw;
    logic signed [RAW_W-1:0] accel_z_raw;
    logic signed [RAW_W-1:0] temp_raw;
    logic signed [RAW_W-1:0] gyro_x_raw;
    logic signed [RAW_W-1:0] gyro_y_raw;
    logic signed [RAW_W-1:0] gyro_z_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] accel_x_out;
    logic signed [OUT_W-1:0] accel_y_out;
    logic signed [OUT_W-1:0] accel_z_out;
    logic signed [OUT_W-1:0] temp_out;
    logic signed [OUT_W-1:0] gyro_x_out;
    logic signed [OUT_W-1:0] gyro_y_out;
    logic signed [OUT_W-1:0] gyro_z_out;
  } out_item_t;

  // pipeline control for the lanes; temperature uses a copy with filtering off
  typedef struct packed {
    logic                 acc;
    logic                 filt;
    logic [RING_LOG2-1:0] slot;
    logic                 en2;
    logic                 en3;
    logic                 filt_s2;
  } lane_ctrl_t;

endpackage

`default_nettype wire

/* rtl/isaa_ring_lane.sv */
// ----------------------------------------------------------------------------
// isaa_ring_lane
// Per-channel ring of raw counts with a running sum; first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module isaa_ring_lane
  import isaa_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire lane_ctrl_t          ctrl_i,
  input  wire logic signed [RAW_W-1:0] raw_i,
  output logic signed [SUM_W-1:0]  val_o
);

  logic signed [RAW_W-1:0] ring_q [TAPS];
  logic signed [SUM_W-1:0] rsum_q;
  logic signed [SUM_W-1:0] rsum_d;
  logic signed [SUM_W-1:0] val_q;

  assign rsum_d = rsum_q - SUM_W'(ring_q[ctrl_i.slot]) + SUM_W'(raw_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        ring_q[i] <= '0;
      end
      rsum_q <= '0;
    end else if (ctrl_i.acc && ctrl_i.filt) begin
      ring_q[ctrl_i.slot] <= raw_i;
      rsum_q              <= rsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      val_q <= ctrl_i.filt ? rsum_d : SUM_W'(raw_i);
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* rtl/isaa_scale_lane.sv */
// ----------------------------------------------------------------------------
// isaa_scale_lane
// Gain multiply, floor shift, bias add and 32-bit saturation for one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module isaa_scale_lane
  import isaa_pkg::*;
(
  input  wire                          clk_i,
  input  wire lane_ctrl_t              ctrl_i,
  input  wire logic signed [SUM_W-1:0] val_i,
  input  wire logic [GAIN_W-1:0]       gain_i,
  input  wire logic signed [CFG_W-1:0] bias_i,
  output logic signed [OUT_W-1:0]      res_o
);

  logic signed [PROD_W-1:0]    prod_q;
  logic signed [PROD_W-1:0]    prod_d;
  logic signed [PROD_W-1:0]    shifted;
  logic signed [PROD_W:0]      total;
  logic [PROD_W-OUT_W+1:0]     hi_bits;
  logic signed [OUT_W-1:0]     res_d;
  logic signed [OUT_W-1:0]     res_q;

  assign prod_d = PROD_W'(val_i) * PROD_W'($signed({1'b0, gain_i}));

  always_comb begin
    shifted = ctrl_i.filt_s2 ? (prod_q >>> (FRAC_SHIFT + RING_LOG2))
                             : (prod_q >>> FRAC_SHIFT);
    total   = (PROD_W + 1)'(shifted) + (PROD_W + 1)'(bias_i);
    hi_bits = total[PROD_W:OUT_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      res_d = total[OUT_W-1:0];
    end else if (total[PROD_W]) begin
      res_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.en3) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* rtl/imu_sample_scale_and_average_core.sv */
// ----------------------------------------------------------------------------
// imu_sample_scale_and_average_core
// Scales raw six-axis IMU samples and temperature to Q16.16, with an optional
// moving average over the motion channels.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one raw sample per transaction.
// Output channel: out_valid_o / out_stall_i carry seven saturated Q16.16
// values per transaction, in input order.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i;
// write only while no transaction is in flight.
// Path: an accepted input is registered in the ring stage, then the product and
// output registers. Throughput: one transaction per cycle while the output is
// not stalled. Seven lanes run side by side, each a three-stage pipe (ring update
// with running sum or, for temperature, a plain register; gain multiply; saturate).
// Reset: gains, bias and filter enable take their defaults, rings and running
// sums clear to zero, the pipe empties. No clearing pass is needed.
// Stall: each stage holds only while the stage after it is full and held, so
// bubbles collapse and inputs are still taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_scale_and_average_core
  import isaa_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output out_item_t                  out_data_o,
  input  wire                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  logic [GAIN_W-1:0]       accel_gain_q;
  logic [GAIN_W-1:0]       gyro_gain_q;
  logic [GAIN_W-1:0]       temp_gain_q;
  logic signed [CFG_W-1:0] temp_bias_q;
  logic                    filter_en_q;

  logic [RING_LOG2-1:0]    slot_q;
  logic                    v1_q, v2_q, v3_q;
  logic                    f1_q, f2_q;
  logic                    adv1, adv2, adv3;
  logic                    acc;
  lane_ctrl_t              ctrl;
  lane_ctrl_t              ctrl_tmp;

  logic signed [SUM_W-1:0] temp_val_q;
  logic signed [SUM_W-1:0] mot_val [6];
  logic signed [OUT_W-1:0] mot_res [6];
  logic signed [OUT_W-1:0] temp_res;
  logic signed [RAW_W-1:0] mot_raw [6];
  logic [GAIN_W-1:0]       mot_gain [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= ACCEL_GAIN_RST;
      gyro_gain_q  <= GYRO_GAIN_RST;
      temp_gain_q  <= TEMP_GAIN_RST;
      temp_bias_q  <= TEMP_BIAS_RST;
      filter_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_GAIN:    accel_gain_q <= cfg_data_i;
        REG_GYRO_GAIN:     gyro_gain_q  <= cfg_data_i;
        REG_TEMP_GAIN:     temp_gain_q  <= cfg_data_i;
        REG_TEMP_BIAS:     temp_bias_q  <= cfg_data_i;
        REG_FILTER_ENABLE: filter_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign acc  = in_valid_i && adv1;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      f1_q   <= 1'b0;
      f2_q   <= 1'b0;
      slot_q <= '0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (acc) f1_q <= filter_en_q;
      if (adv2 && v1_q) f2_q <= f1_q;
      if (acc && filter_en_q) slot_q <= slot_q + 1'b1;
    end
  end

  always_comb begin
    ctrl.acc     = acc;
    ctrl.filt    = filter_en_q;
    ctrl.slot    = slot_q;
    ctrl.en2     = adv2 && v1_q;
    ctrl.en3     = adv3 && v2_q;
    ctrl.filt_s2 = f2_q;
    ctrl_tmp         = ctrl;
    ctrl_tmp.filt    = 1'b0;
    ctrl_tmp.filt_s2 = 1'b0;
  end

  assign mot_raw[0]  = in_data_i.accel_x_raw;
  assign mot_raw[1]  = in_data_i.accel_y_raw;
  assign mot_raw[2]  = in_data_i.accel_z_raw;
  assign mot_raw[3]  = in_data_i.gyro_x_raw;
  assign mot_raw[4]  = in_data_i.gyro_y_raw;
  assign mot_raw[5]  = in_data_i.gyro_z_raw;
  assign mot_gain[0] = accel_gain_q;
  assign mot_gain[1] = accel_gain_q;
  assign mot_gain[2] = accel_gain_q;
  assign mot_gain[3] = gyro_gain_q;
  assign mot_gain[4] = gyro_gain_q;
  assign mot_gain[5] = gyro_gain_q;

  for (genvar g = 0; g < 6; g++) begin : g_lane
    isaa_ring_lane u_ring (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .raw_i  (mot_raw[g]),
      .val_o  (mot_val[g])
    );
    isaa_scale_lane u_scale (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .val_i  (mot_val[g]),
      .gain_i (mot_gain[g]),
      .bias_i ('0),
      .res_o  (mot_res[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      temp_val_q <= SUM_W'(in_data_i.temp_raw);
    end
  end

  isaa_scale_lane u_temp (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_tmp),
    .val_i  (temp_val_q),
    .gain_i (temp_gain_q),
    .bias_i (temp_bias_q),
    .res_o  (temp_res)
  );

  always_comb begin
    out_data_o.accel_x_out = mot_res[0];
    out_data_o.accel_y_out = mot_res[1];
    out_data_o.accel_z_out = mot_res[2];
    out_data_o.temp_out    = temp_res;
    out_data_o.gyro_x_out  = mot_res[3];
    out_data_o.gyro_y_out  = mot_res[4];
    out_data_o.gyro_z_out  = mot_res[5];
  end

  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

/* rtl/isaa_checker.sv */
// ----------------------------------------------------------------------------
// isaa_checker
// Port-level checks on the IMU scaling core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module isaa_checker
  import isaa_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input wire out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction dropped or changed while stalled");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side is moving");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted transaction missing after three free cycles");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind imu_sample_scale_and_average_core isaa_checker u_isaa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
